### rtl/asfc_pkg.sv
`default_nettype none

package asfc_pkg;

   // Sample format codes
   localparam logic [2:0] FMT_S8    = 3'd0;
   localparam logic [2:0] FMT_U8    = 3'd1;
   localparam logic [2:0] FMT_S16LE = 3'd2;
   localparam logic [2:0] FMT_S16BE = 3'd3;
   localparam logic [2:0] FMT_U16LE = 3'd4;
   localparam logic [2:0] FMT_U16BE = 3'd5;
   localparam logic [2:0] FMT_S32LE = 3'd6;
   localparam logic [2:0] FMT_S32BE = 3'd7;

   // Register indexes
   localparam logic REG_FORMAT = 1'b0;
   localparam logic REG_GAIN   = 1'b1;

   localparam int          GAIN_W     = 24;
   localparam logic [2:0]  FMT_RESET  = FMT_S16LE;
   localparam logic [23:0] GAIN_RESET = 24'd65536;

   localparam logic [2:0] BYTES_1 = 3'd1;
   localparam logic [2:0] BYTES_2 = 3'd2;
   localparam logic [2:0] BYTES_4 = 3'd4;

   localparam logic [30:0] K_8  = 31'd127;
   localparam logic [30:0] K_16 = 31'd32767;
   localparam logic [30:0] K_32 = 31'd2147483647;

   typedef struct packed {
      logic [30:0] k;
      logic [2:0]  nbytes;
      logic        is_unsigned;
      logic        big;
   } fmt_info_type;

   typedef struct packed {
      logic adv1;
      logic adv2;
   } pipe_ctl_type;

   function automatic fmt_info_type decode_format(input logic [2:0] fmt);
      fmt_info_type info;
      info = '{k: K_32, nbytes: BYTES_4, is_unsigned: 1'b0, big: 1'b1};
      case (fmt)
         FMT_S8:    info = '{k: K_8,  nbytes: BYTES_1, is_unsigned: 1'b0, big: 1'b0};
         FMT_U8:    info = '{k: K_8,  nbytes: BYTES_1, is_unsigned: 1'b1, big: 1'b0};
         FMT_S16LE: info = '{k: K_16, nbytes: BYTES_2, is_unsigned: 1'b0, big: 1'b0};
         FMT_S16BE: info = '{k: K_16, nbytes: BYTES_2, is_unsigned: 1'b0, big: 1'b1};
         FMT_U16LE: info = '{k: K_16, nbytes: BYTES_2, is_unsigned: 1'b1, big: 1'b0};
         FMT_U16BE: info = '{k: K_16, nbytes: BYTES_2, is_unsigned: 1'b1, big: 1'b1};
         FMT_S32LE: info = '{k: K_32, nbytes: BYTES_4, is_unsigned: 1'b0, big: 1'b0};
         default:   info = '{k: K_32, nbytes: BYTES_4, is_unsigned: 1'b0, big: 1'b1};
      endcase
      return info;
   endfunction

endpackage

`default_nettype wire

### rtl/asfc_csr.sv
`default_nettype none

module asfc_csr
   import asfc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [2:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic      [31:0]       prdata,
   output logic                   pready,
   output logic      [2:0]        fmt,
   output logic      [GAIN_W-1:0] gain
);

   logic [2:0]        fmt_ff, fmt_in;
   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic              wr_en;
   logic              reg_idx;

   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[2];

   always_comb begin
      fmt_in  = fmt_ff;
      gain_in = gain_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_FORMAT: fmt_in  = pwdata[2:0];
            REG_GAIN:   gain_in = pwdata[GAIN_W-1:0];
            default:    fmt_in  = fmt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff  <= FMT_RESET;
         gain_ff <= GAIN_RESET;
      end else begin
         fmt_ff  <= fmt_in;
         gain_ff <= gain_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_FORMAT: prdata = {29'd0, fmt_ff};
         REG_GAIN:   prdata = {{(32-GAIN_W){1'b0}}, gain_ff};
         default:    prdata = 32'd0;
      endcase
   end

   assign pready = 1'b1;
   assign fmt    = fmt_ff;
   assign gain   = gain_ff;

endmodule

`default_nettype wire

### rtl/asfc_lane.sv
`default_nettype none

module asfc_lane
   import asfc_pkg::*;
#(
   parameter int FRAC_BITS = 24
) (
   input  wire logic              clock,
   input  wire pipe_ctl_type      ctl,
   input  wire fmt_info_type      info,
   input  wire logic [GAIN_W-1:0] gain,
   input  wire logic [31:0]       sample,
   output logic      [31:0]       word
);

   localparam int OPW = FRAC_BITS + 2;
   localparam int MW  = OPW + 31;
   localparam logic [39:0]    ONE_S = 40'(1) << FRAC_BITS;
   localparam logic [OPW-1:0] ONE_O = OPW'(1) << FRAC_BITS;

   // Stage 1: magnitude times gain
   logic [31:0] mag;
   logic [55:0] prod_ff, prod_in;
   logic        neg1_ff, neg1_in;

   assign mag     = sample[31] ? (32'd0 - sample) : sample;
   assign prod_in = 56'(mag) * 56'(gain);
   assign neg1_in = sample[31];

   always_ff @(posedge clock) begin
      if (ctl.adv1) begin
         prod_ff <= prod_in;
         neg1_ff <= neg1_in;
      end
   end

   // Stage 2: truncate, clamp to full scale, scale to format
   logic [39:0]        scaled;
   logic [FRAC_BITS:0] mag_c;
   logic               neg_c;
   logic [OPW-1:0]     op;
   logic [MW-1:0]      full;
   logic [31:0]        q_ff, q_in;
   logic               neg2_ff, neg2_in;

   assign scaled = prod_ff[55:16];
   assign mag_c  = (scaled > ONE_S) ? ONE_S[FRAC_BITS:0] : scaled[FRAC_BITS:0];
   assign neg_c  = neg1_ff & (mag_c != '0);

   always_comb begin
      if (info.is_unsigned) begin
         op = neg_c ? (ONE_O - OPW'(mag_c)) : (ONE_O + OPW'(mag_c));
      end else begin
         op = OPW'(mag_c);
      end
   end

   assign full    = MW'(op) * MW'(info.k);
   assign q_in    = full[FRAC_BITS+31:FRAC_BITS];
   assign neg2_in = neg_c & ~info.is_unsigned;

   always_ff @(posedge clock) begin
      if (ctl.adv2) begin
         q_ff    <= q_in;
         neg2_ff <= neg2_in;
      end
   end

   // Stage 3 logic: sign, width mask, byte order
   logic [31:0] v;

   assign v = neg2_ff ? (32'd0 - q_ff) : q_ff;

   always_comb begin
      case (info.nbytes)
         BYTES_1: word = {24'd0, v[7:0]};
         BYTES_2: word = info.big ? {16'd0, v[7:0], v[15:8]} : {16'd0, v[15:0]};
         default: word = info.big ? {v[7:0], v[15:8], v[23:16], v[31:24]} : v;
      endcase
   end

endmodule

`default_nettype wire

### rtl/audio_sample_format_converter.sv
`default_nettype none

// Stereo PCM format converter with volume gain. Each transaction on the req_
// channel carries one stereo frame of signed fixed-point samples (1.0 equals
// 2^FRAC_BITS); each transaction on the rsp_ channel returns the two samples
// scaled by the Q8.16 gain, clamped to full scale, converted to the format held
// in the format register and packed in stream byte order, with the byte count
// and the end-of-buffer flag. Two identical lanes convert left and right side
// by side. The block takes one frame per clock unless rsp_ready low has filled
// the pipeline; the depth is set by the two multipliers in each lane (sample times
// gain, then clamped value times format full scale), each followed by a
// register, plus the output register. With rsp_ready held low the three
// stages fill and req_ready drops. Registers: format at byte address 0, gain at
// byte address 4; write them only while no transaction is in flight.
module audio_sample_format_converter
   import asfc_pkg::*;
#(
   parameter int FRAC_BITS = 24
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input frames
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_left_sample,
   input  wire logic [31:0] req_right_sample,
   input  wire logic        req_frame_last,
   // converted frames
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [31:0] rsp_left_word,
   output logic      [31:0] rsp_right_word,
   output logic      [2:0]  rsp_sample_bytes,
   output logic             rsp_last_out,
   // register port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready
);

   logic [2:0]        fmt;
   logic [GAIN_W-1:0] gain;
   fmt_info_type      info;
   pipe_ctl_type      ctl;
   logic [31:0]       left_word, right_word;

   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic last1_ff, last2_ff;
   logic adv3;
   logic [31:0] left_ff, right_ff;
   logic [2:0]  bytes_ff;
   logic        last3_ff;

   asfc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .fmt     (fmt),
      .gain    (gain)
   );

   assign info = decode_format(fmt);

   // Advance a stage when the one after it is empty or moving on
   assign adv3     = ~v3_ff | rsp_ready;
   assign ctl.adv2 = ~v2_ff | adv3;
   assign ctl.adv1 = ~v1_ff | ctl.adv2;
   assign req_ready = ctl.adv1;

   assign v1_in = ctl.adv1 ? req_valid : v1_ff;
   assign v2_in = ctl.adv2 ? v1_ff     : v2_ff;
   assign v3_in = adv3     ? v2_ff     : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   asfc_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_left (
      .clock  (clock),
      .ctl    (ctl),
      .info   (info),
      .gain   (gain),
      .sample (req_left_sample),
      .word   (left_word)
   );

   asfc_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_right (
      .clock  (clock),
      .ctl    (ctl),
      .info   (info),
      .gain   (gain),
      .sample (req_right_sample),
      .word   (right_word)
   );

   // Carry the end-of-buffer flag alongside the lanes
   always_ff @(posedge clock) begin
      if (ctl.adv1) begin
         last1_ff <= req_frame_last;
      end
      if (ctl.adv2) begin
         last2_ff <= last1_ff;
      end
   end

   // Merge both lanes into the output register
   always_ff @(posedge clock) begin
      if (adv3) begin
         left_ff  <= left_word;
         right_ff <= right_word;
         bytes_ff <= info.nbytes;
         last3_ff <= last2_ff;
      end
   end

   assign rsp_valid        = v3_ff;
   assign rsp_left_word    = left_ff;
   assign rsp_right_word   = right_ff;
   assign rsp_sample_bytes = bytes_ff;
   assign rsp_last_out     = last3_ff;

   // An empty output register never holds back the input side
   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with empty output register");

   // An accepted transaction always lands in the first stage
   a_accept_fills : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> v1_ff)
      else $error("accepted transaction lost at first stage");

   a_bytes_legal : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sample_bytes == BYTES_1 || rsp_sample_bytes == BYTES_2 ||
                     rsp_sample_bytes == BYTES_4))
      else $error("illegal byte count");

   // Drop unused bytes: the upper bytes of two-byte samples must read as zero
   a_upper_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_sample_bytes == BYTES_2) |->
         (rsp_left_word[31:16] == 16'd0 && rsp_right_word[31:16] == 16'd0))
      else $error("unused upper bytes not zero");

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 100ps

// Self-checking bench for the stereo PCM format converter.
// A short table of directed frames covers the register reset values, full scale,
// clamping, zero gain, truncation toward zero and every sample format.
// Randomised phases then follow, each with its own format and gain setting.
// Every accepted frame is converted by the bench's own model, and each
// response transaction is compared field by field with the oldest conversion
// still outstanding.
module testbench;
   import asfc_pkg::*;

   localparam int          FRAC             = 24;
   localparam int          HALF_PERIOD      = 5;
   localparam int          RESET_CYCLES     = 8;
   localparam int          SETTLE_CYCLES    = 4;   // pipeline is three deep
   localparam int          DRAIN_CYCLES     = 8;
   localparam int          HOLD_CYCLES      = 40;
   localparam int          PHASES           = 16;
   localparam int          FRAMES_PER_PHASE = 115;
   localparam int          DIRECTED_ROWS    = 20;
   localparam int          LIMIT_CYCLES     = 200_000;
   localparam logic [31:0] UNITY_SAMPLE     = 32'h0100_0000;
   localparam logic [31:0] MINUS_ONE_SAMPLE = 32'hFF00_0000;

   typedef struct packed {
      logic [31:0] left_word;
      logic [31:0] right_word;
      logic [2:0]  sample_bytes;
      logic        last_out;
   } converted_frame_type;

   // One directed frame with the setting it runs under. Where typed is set,
   // the expected words are written into the row instead of being converted.
   typedef struct packed {
      logic [2:0]  fmt;
      logic [23:0] gain;
      logic [31:0] left;
      logic [31:0] right;
      logic        last;
      logic        typed;
      logic [31:0] want_left;
      logic [31:0] want_right;
   } stim_row_type;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic [31:0] req_left_sample  = '0;
   logic [31:0] req_right_sample = '0;
   logic        req_frame_last   = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic [31:0] rsp_left_word;
   logic [31:0] rsp_right_word;
   logic [2:0]  rsp_sample_bytes;
   logic        rsp_last_out;
   logic        psel             = 1'b0;
   logic        penable          = 1'b0;
   logic        pwrite           = 1'b0;
   logic [2:0]  paddr            = '0;
   logic [31:0] pwdata           = '0;
   logic [31:0] prdata;
   logic        pready;

   // Register mirror, updated as each write completes
   logic [2:0]  fmt_cfg  = FMT_RESET;
   logic [23:0] gain_cfg = GAIN_RESET;

   // Conversion of the frame currently offered; pushed when its transaction lands
   converted_frame_type offered_frame = '0;
   converted_frame_type pending_frames[$];

   // Handshake pacing shared with the response side
   logic        idling        = 1'b1;
   int unsigned hold_requests = 0;
   int unsigned holds_served  = 0;
   int unsigned ready_gap     = 0;

   int unsigned frames_checked   = 0;
   int unsigned settings_applied = 0;
   int unsigned error_count      = 0;
   int unsigned cycle_count      = 0;

   stim_row_type directed_rows [DIRECTED_ROWS];

   audio_sample_format_converter #(.FRAC_BITS(FRAC)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_left_sample  (req_left_sample),
      .req_right_sample (req_right_sample),
      .req_frame_last   (req_frame_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_left_word    (rsp_left_word),
      .rsp_right_word   (rsp_right_word),
      .rsp_sample_bytes (rsp_sample_bytes),
      .rsp_last_out     (rsp_last_out),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #HALF_PERIOD clock = ~clock;

   // Convert one channel: gain, truncate, clamp, scale to the format, then
   // place the bytes in stream order.
   function automatic logic [31:0] convert_channel(input logic [31:0] raw);
      logic        neg;
      logic        uns;
      logic        big;
      logic [2:0]  nbytes;
      logic [63:0] full_scale;
      logic [63:0] mag;
      logic [63:0] k;
      logic [63:0] q;
      logic [31:0] v;
      full_scale = 64'd1 << FRAC;
      neg = raw[31];
      mag = {32'd0, (neg ? (~raw + 32'd1) : raw)};
      mag = (mag * {40'd0, gain_cfg}) >> 16;
      if (mag > full_scale) begin
         mag = full_scale;
      end
      // a product truncated to nothing is treated as positive
      if (mag == 64'd0) begin
         neg = 1'b0;
      end
      uns = 1'b0;
      big = 1'b0;
      case (fmt_cfg)
         FMT_S8: begin
            k = {33'd0, K_8};  nbytes = BYTES_1;
         end
         FMT_U8: begin
            k = {33'd0, K_8};  nbytes = BYTES_1; uns = 1'b1;
         end
         FMT_S16LE: begin
            k = {33'd0, K_16}; nbytes = BYTES_2;
         end
         FMT_S16BE: begin
            k = {33'd0, K_16}; nbytes = BYTES_2; big = 1'b1;
         end
         FMT_U16LE: begin
            k = {33'd0, K_16}; nbytes = BYTES_2; uns = 1'b1;
         end
         FMT_U16BE: begin
            k = {33'd0, K_16}; nbytes = BYTES_2; uns = 1'b1; big = 1'b1;
         end
         FMT_S32LE: begin
            k = {33'd0, K_32}; nbytes = BYTES_4;
         end
         default: begin
            k = {33'd0, K_32}; nbytes = BYTES_4; big = 1'b1;
         end
      endcase
      if (uns) begin
         q = ((neg ? (full_scale - mag) : (full_scale + mag)) * k) >> FRAC;
         v = q[31:0];
      end else begin
         q = (mag * k) >> FRAC;
         v = neg ? (32'd0 - q[31:0]) : q[31:0];
      end
      case (nbytes)
         BYTES_1: v = {24'd0, v[7:0]};
         BYTES_2: v = big ? {16'd0, v[7:0], v[15:8]} : {16'd0, v[15:0]};
         default: if (big) begin
            v = {v[7:0], v[15:8], v[23:16], v[31:24]};
         end
      endcase
      return v;
   endfunction

   function automatic converted_frame_type convert_frame(input logic [31:0] left,
                                                         input logic [31:0] right,
                                                         input logic last);
      converted_frame_type f;
      f.left_word  = convert_channel(left);
      f.right_word = convert_channel(right);
      if (fmt_cfg <= FMT_U8) begin
         f.sample_bytes = BYTES_1;
      end else if (fmt_cfg <= FMT_U16BE) begin
         f.sample_bytes = BYTES_2;
      end else begin
         f.sample_bytes = BYTES_4;
      end
      f.last_out = last;
      return f;
   endfunction

   // Mix of sample magnitudes: anything at all, inside full scale, a few times
   // over it, close to zero, and the exact corners.
   function automatic logic [31:0] draw_sample();
      logic [31:0] s;
      case ($urandom_range(0, 5))
         0: s = $urandom;
         1: s = $urandom_range(0, 2 * UNITY_SAMPLE) - UNITY_SAMPLE;
         2: s = $urandom_range(0, 512) - 32'd256;
         3: begin
            case ($urandom_range(0, 7))
               0: s = UNITY_SAMPLE;
               1: s = MINUS_ONE_SAMPLE;
               2: s = UNITY_SAMPLE + 32'd1;
               3: s = MINUS_ONE_SAMPLE - 32'd1;
               4: s = 32'h7FFF_FFFF;
               5: s = 32'h8000_0000;
               6: s = 32'hFFFF_FFFF;
               default: s = 32'd0;
            endcase
         end
         default: s = $urandom_range(0, 8 * UNITY_SAMPLE) - 4 * UNITY_SAMPLE;
      endcase
      return s;
   endfunction

   // Offer one frame on the request channel and hold it until it is taken.
   // An optional idle burst goes in front; valid stays high otherwise.
   task automatic offer_frame(input logic [31:0] left, input logic [31:0] right,
                              input logic last, input logic typed,
                              input logic [31:0] want_left, input logic [31:0] want_right);
      converted_frame_type f;
      if (idling && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      f = convert_frame(left, right, last);
      if (typed) begin
         f.left_word  = want_left;
         f.right_word = want_right;
      end
      req_valid        <= 1'b1;
      req_left_sample  <= left;
      req_right_sample <= right;
      req_frame_last   <= last;
      offered_frame    <= f;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic csr_write(input logic reg_idx, input logic [31:0] data);
      paddr   <= {reg_idx, 2'b00};
      pwdata  <= data;
      pwrite  <= 1'b1;
      psel    <= 1'b1;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (reg_idx == REG_FORMAT) begin
         fmt_cfg = data[2:0];
      end else begin
         gain_cfg = data[GAIN_W-1:0];
      end
   endtask

   task automatic csr_check(input logic reg_idx, input logic [31:0] want);
      paddr   <= {reg_idx, 2'b00};
      pwrite  <= 1'b0;
      psel    <= 1'b1;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== want) begin
         $error("register %0d readback: expected %h, got %h", reg_idx, want, prdata);
         error_count++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Drain the pipe, then load a new format and gain and read both back
   task automatic retune(input logic [31:0] fmt_word, input logic [31:0] gain_word);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write(REG_FORMAT, fmt_word);
      csr_write(REG_GAIN, gain_word);
      csr_check(REG_FORMAT, {29'd0, fmt_cfg});
      csr_check(REG_GAIN, {8'd0, gain_cfg});
      settings_applied++;
   endtask

   // Response side: ready is high by default, dropped in short random bursts
   // while idling is on, and held low for a long stretch on each hold request
   // so that the pipe fills and the request side stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_gap <= 0;
      end else if (holds_served != hold_requests) begin
         holds_served <= hold_requests;
         ready_gap    <= HOLD_CYCLES - 1;
         rsp_ready    <= 1'b0;
      end else if (ready_gap != 0) begin
         ready_gap <= ready_gap - 1;
      end else if (idling && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         ready_gap <= $urandom_range(0, 2);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Scoreboard: retire the oldest conversion on each response transaction,
   // then queue the conversion of any frame accepted at this edge.
   always @(posedge clock) begin
      converted_frame_type want;
      if (!reset) begin
         if (rsp_valid === 1'b1 && rsp_ready) begin
            if (pending_frames.size() == 0) begin
               $error("response transaction with no frame outstanding");
               error_count++;
            end else begin
               want = pending_frames.pop_front();
               frames_checked++;
               if (rsp_left_word !== want.left_word) begin
                  $error("left_word: expected %h, got %h", want.left_word, rsp_left_word);
                  error_count++;
               end
               if (rsp_right_word !== want.right_word) begin
                  $error("right_word: expected %h, got %h", want.right_word, rsp_right_word);
                  error_count++;
               end
               if (rsp_sample_bytes !== want.sample_bytes) begin
                  $error("sample_bytes: expected %0d, got %0d",
                         want.sample_bytes, rsp_sample_bytes);
                  error_count++;
               end
               if (rsp_last_out !== want.last_out) begin
                  $error("last_out: expected %b, got %b", want.last_out, rsp_last_out);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready === 1'b1) begin
            pending_frames.push_back(offered_frame);
         end
      end
   end

   // Watchdog: stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timed out after %0d cycles, %0d frames outstanding",
                  cycle_count, pending_frames.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      stim_row_type row;
      logic [31:0]  fmt_word;
      logic [31:0]  gain_word;

      // fmt, gain, left, right, last, typed, expected left, expected right
      directed_rows = '{
         // reset setting: silence, full scale both ways, overrange, tiny negative
         '{FMT_S16LE, 24'h01_0000, 32'h0, 32'h0, 1'b0, 1'b1, 32'h0, 32'h0},
         '{FMT_S16LE, 24'h01_0000, UNITY_SAMPLE, MINUS_ONE_SAMPLE, 1'b1, 1'b1,
           32'h7FFF, 32'h8001},
         '{FMT_S16LE, 24'h01_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1,
           32'h7FFF, 32'h8001},
         '{FMT_S16LE, 24'h01_0000, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 1'b1,
           32'h0, 32'h0},
         '{FMT_S8, 24'h01_0000, UNITY_SAMPLE, MINUS_ONE_SAMPLE, 1'b0, 1'b1,
           32'h7F, 32'h81},
         '{FMT_U8, 24'h01_0000, UNITY_SAMPLE, MINUS_ONE_SAMPLE, 1'b1, 1'b1,
           32'hFE, 32'h00},
         '{FMT_U8, 24'h01_0000, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b1, 32'h7E, 32'h7F},
         // zero gain: a negative sample becomes plain zero, mid-scale unsigned
         '{FMT_U8, 24'h00_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1,
           32'h7F, 32'h7F},
         '{FMT_S16BE, 24'h01_0000, UNITY_SAMPLE, MINUS_ONE_SAMPLE, 1'b0, 1'b1,
           32'hFF7F, 32'h0180},
         '{FMT_U16LE, 24'h01_0000, UNITY_SAMPLE, MINUS_ONE_SAMPLE, 1'b1, 1'b1,
           32'hFFFE, 32'h0},
         '{FMT_U16BE, 24'h01_0000, 32'h0, UNITY_SAMPLE, 1'b0, 1'b1,
           32'hFF7F, 32'hFEFF},
         '{FMT_S32LE, 24'h01_0000, UNITY_SAMPLE, MINUS_ONE_SAMPLE, 1'b1, 1'b1,
           32'h7FFF_FFFF, 32'h8000_0001},
         '{FMT_S32BE, 24'h01_0000, UNITY_SAMPLE, MINUS_ONE_SAMPLE, 1'b0, 1'b1,
           32'hFFFF_FF7F, 32'h0100_0080},
         // full gain on small samples, and clamping at full gain
         '{FMT_S32BE, 24'hFF_FFFF, 32'h0000_1234, 32'hFFFF_0001, 1'b1, 1'b0, 32'h0, 32'h0},
         '{FMT_S32LE, 24'hFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1,
           32'h7FFF_FFFF, 32'h8000_0001},
         // half gain on full scale
         '{FMT_S32LE, 24'h00_8000, UNITY_SAMPLE, MINUS_ONE_SAMPLE, 1'b1, 1'b1,
           32'h3FFF_FFFF, 32'hC000_0001},
         '{FMT_S16LE, 24'h01_8000, 32'h00C0_0000, 32'hFF40_0000, 1'b0, 1'b0, 32'h0, 32'h0},
         '{FMT_S8, 24'h12_3456, 32'h00A5_A5A5, 32'hFF5A_5A5B, 1'b1, 1'b0, 32'h0, 32'h0},
         '{FMT_U16BE, 24'h00_FFFF, 32'h0080_0000, 32'hFF80_0000, 1'b0, 1'b0, 32'h0, 32'h0},
         // minimum non-zero gain on the extremes
         '{FMT_U8, 24'h00_0001, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0, 32'h0, 32'h0}
      };

      // Hold reset, release it and confirm the register reset values
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_check(REG_FORMAT, {29'd0, FMT_RESET});
      csr_check(REG_GAIN, {8'd0, GAIN_RESET});

      // Directed table; retune only where a row asks for a new setting
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = directed_rows[i];
         if (row.fmt != fmt_cfg || row.gain != gain_cfg) begin
            retune({29'd0, row.fmt}, {8'd0, row.gain});
         end
         offer_frame(row.left, row.right, row.last, row.typed, row.want_left, row.want_right);
      end

      // Random phases: walk every format, hit the gain extremes first, and
      // put junk in the unused register bits so the masking is exercised
      for (int p = 0; p < PHASES; p++) begin
         fmt_word = ($urandom & 32'hFFFF_FFF8) | (p % 8);
         case (p)
            0:       gain_word = GAIN_RESET;
            1:       gain_word = 32'd0;
            2:       gain_word = 32'h00FF_FFFF;
            3:       gain_word = 32'd1;
            default: gain_word = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'h00FF_FFFF)
                                                              : $urandom_range(0, 32'h0002_0000);
         endcase
         gain_word = gain_word | ($urandom & 32'hFF00_0000);
         retune(fmt_word, gain_word);
         // no idling every fourth phase and none at all over the last two
         idling <= (p % 4 != 2) && (p < PHASES - 2);
         if (p == 5 || p == 11) begin
            hold_requests <= hold_requests + 1;
         end
         for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
            offer_frame(draw_sample(), draw_sample(), 1'($urandom_range(0, 1)),
                        1'b0, 32'd0, 32'd0);
         end
      end

      // Drop valid, wait for the pipe to empty, then let it settle
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d converted frames across %0d format and gain settings",
               frames_checked, settings_applied);
      $display("all eight formats, gain from zero to full range, %0d long output holds",
               holds_served);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
